// ----- hdl/ism_pkg.sv -----
`timescale 1ns / 1ps

package ism_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int VAL_W       = 31;
  localparam int OPND_W      = 30;
  localparam int TYPE_W      = 4;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int CNT_W       = $clog2(VAL_W);

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [OPND_W-1:0] operand;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic                    is_error;
  } rsp_t;

  typedef enum logic [TYPE_W-1:0] {
    OP_START = 4'd0,
    OP_PUSH  = 4'd1,
    OP_POP   = 4'd2,
    OP_NEG   = 4'd3,
    OP_DUP   = 4'd4,
    OP_SWAP  = 4'd5,
    OP_ADD   = 4'd6,
    OP_SUB   = 4'd7,
    OP_MUL   = 4'd8,
    OP_DIV   = 4'd9,
    OP_MOD   = 4'd10,
    OP_END   = 4'd11
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [OPND_W-1:0] operand;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FILL
  } state_t;

  function automatic logic out_of_range(input logic signed [63:0] v);
    return (v > 64'sd1000000000) || (v < -64'sd1000000000);
  endfunction

endpackage

// ----- hdl/ism_ram.sv -----
`timescale 1ns / 1ps

module ism_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ism_div.sv -----
`timescale 1ns / 1ps

module ism_div import ism_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [VAL_W-1:0] dividend,
  input  logic signed [VAL_W-1:0] divisor,
  output logic                    done,
  output logic signed [VAL_W-1:0] quot,
  output logic signed [VAL_W-1:0] rem
);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [VAL_W-1:0] den;
  logic [VAL_W-1:0] qd;
  logic [VAL_W-1:0] r;
  logic             negq;
  logic             negr;

  logic [VAL_W-1:0] mag_n;
  logic [VAL_W-1:0] mag_d;
  logic [VAL_W:0]   t;
  logic             ge;
  logic [VAL_W:0]   r_next;

  assign mag_n  = dividend[VAL_W-1] ? VAL_W'(-dividend) : VAL_W'(dividend);
  assign mag_d  = divisor[VAL_W-1] ? VAL_W'(-divisor) : VAL_W'(divisor);
  assign t      = {r, qd[VAL_W-1]};
  assign ge     = t >= {1'b0, den};
  assign r_next = ge ? t - {1'b0, den} : t;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && cnt == CNT_W'(VAL_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= '0;
      den  <= mag_d;
      qd   <= mag_n;
      r    <= '0;
      negq <= dividend[VAL_W-1] ^ divisor[VAL_W-1];
      negr <= dividend[VAL_W-1];
    end else if (running) begin
      cnt <= cnt + CNT_W'(1);
      r   <= r_next[VAL_W-1:0];
      qd  <= {qd[VAL_W-2:0], ge};
    end
  end

  assign quot = negq ? -$signed(qd) : $signed(qd);
  assign rem  = negr ? -$signed(r) : $signed(r);

endmodule

// ----- hdl/ism_front.sv -----
`timescale 1ns / 1ps

module ism_front import ism_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       known;
  logic       push;
  logic       pop;

  assign known     = req.req_type <= OP_END;
  assign req_ready = count != 2'd2;
  assign push      = req_valid && req_ready && known;
  assign cmd_valid = count != 2'd0;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{op: op_t'(req.req_type), operand: req.operand};
    end
  end

endmodule

// ----- hdl/ism_back.sv -----
`timescale 1ns / 1ps

module ism_back import ism_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  state_t state, state_next;
  logic [DEPTH_W-1:0]      depth, depth_next;
  logic                    err, err_next;
  logic signed [VAL_W-1:0] tos, tos_next;
  logic signed [VAL_W-1:0] nos, nos_next;
  logic signed [PROD_W-1:0] prod;
  logic                    is_mod;
  logic                    out_valid;
  rsp_t                    out_data;

  logic                    take;
  logic                    live;
  logic                    out_free;
  logic                    go_mul;
  logic                    go_div;
  logic                    go_fill;
  logic                    load_out;
  logic                    ram_we;
  logic [DEPTH_W-1:0]      d_m2;
  logic [DEPTH_W-1:0]      d_m3;
  logic signed [VAL_W-1:0] rdata;
  logic                    div_start;
  logic                    div_done;
  logic signed [VAL_W-1:0] quot;
  logic signed [VAL_W-1:0] rem;
  logic signed [63:0]      r_fin;
  logic                    fin;
  logic                    bad;

  assign d_m2     = depth - DEPTH_W'(2);
  assign d_m3     = depth - DEPTH_W'(3);
  assign out_free = !out_valid || rsp_ready;
  assign live     = !err || cmd.op == OP_START || cmd.op == OP_END;
  assign bad      = err || depth != DEPTH_W'(1);

  ism_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (d_m2[ADDR_W-1:0]),
    .wdata (nos),
    .raddr (d_m3[ADDR_W-1:0]),
    .rdata (rdata)
  );

  ism_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (nos),
    .divisor  (tos),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  always_comb begin
    cmd_ready  = 1'b0;
    take       = 1'b0;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    go_mul     = 1'b0;
    go_div     = 1'b0;
    go_fill    = 1'b0;
    load_out   = 1'b0;
    fin        = 1'b0;
    r_fin      = '0;
    tos_next   = tos;
    nos_next   = nos;
    depth_next = depth;
    err_next   = err;
    case (state)
      ST_IDLE: begin
        cmd_ready = cmd.op != OP_END || out_free;
        take      = cmd_valid && cmd_ready;
        if (take && live) begin
          case (cmd.op)
            OP_START: begin
              err_next   = 1'b0;
              depth_next = DEPTH_W'(1);
              tos_next   = VAL_W'(cmd.operand);
            end
            OP_END: begin
              load_out = 1'b1;
            end
            OP_PUSH, OP_DUP: begin
              if (cmd.op == OP_DUP && depth == '0) begin
                err_next = 1'b1;
              end else if (depth == DEPTH_W'(STACK_DEPTH)) begin
                err_next = 1'b1;
              end else begin
                ram_we     = depth >= DEPTH_W'(2);
                nos_next   = tos;
                tos_next   = (cmd.op == OP_PUSH) ? VAL_W'(cmd.operand) : tos;
                depth_next = depth + DEPTH_W'(1);
              end
            end
            OP_POP, OP_NEG: begin
              if (depth == '0) begin
                err_next = 1'b1;
              end else if (cmd.op == OP_NEG) begin
                tos_next = -tos;
              end else begin
                tos_next   = nos;
                depth_next = depth - DEPTH_W'(1);
                go_fill    = depth >= DEPTH_W'(3);
              end
            end
            default: begin
              if (depth < DEPTH_W'(2)) begin
                err_next = 1'b1;
              end else begin
                case (cmd.op)
                  OP_SWAP: begin
                    tos_next = nos;
                    nos_next = tos;
                  end
                  OP_ADD: begin
                    fin   = 1'b1;
                    r_fin = 64'(tos) + 64'(nos);
                  end
                  OP_SUB: begin
                    fin   = 1'b1;
                    r_fin = 64'(nos) - 64'(tos);
                  end
                  OP_MUL: begin
                    go_mul = 1'b1;
                  end
                  default: begin
                    if (tos == '0) begin
                      err_next = 1'b1;
                    end else begin
                      go_div    = 1'b1;
                      div_start = 1'b1;
                    end
                  end
                endcase
              end
            end
          endcase
        end
      end
      ST_MUL: begin
        fin   = 1'b1;
        r_fin = 64'(prod);
      end
      ST_DIV: begin
        fin   = div_done;
        r_fin = 64'(is_mod ? rem : quot);
      end
      ST_FILL: begin
        nos_next = rdata;
      end
      default: begin
      end
    endcase
    if (fin) begin
      if (out_of_range(r_fin)) begin
        err_next = 1'b1;
      end else begin
        tos_next   = VAL_W'(r_fin);
        depth_next = depth - DEPTH_W'(1);
        go_fill    = depth >= DEPTH_W'(3);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (go_mul) begin
          state_next = ST_MUL;
        end else if (go_div) begin
          state_next = ST_DIV;
        end else if (go_fill) begin
          state_next = ST_FILL;
        end
      end
      ST_MUL: begin
        state_next = go_fill ? ST_FILL : ST_IDLE;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = go_fill ? ST_FILL : ST_IDLE;
        end
      end
      ST_FILL: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      depth     <= '0;
      err       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      depth <= depth_next;
      err   <= err_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tos <= tos_next;
    nos <= nos_next;
    if (go_mul) begin
      prod <= tos * nos;
    end
    if (go_div) begin
      is_mod <= cmd.op == OP_MOD;
    end
    if (load_out) begin
      out_data.result_value <= bad ? '0 : tos;
      out_data.is_error     <= bad;
    end
  end

  assign rsp_valid = out_valid;
  assign rsp       = out_data;

  // stack never grows past its capacity
  assert property (@(posedge clk) disable iff (rst) depth <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth past capacity");

  assert property (@(posedge clk) disable iff (rst) cmd_ready |-> state == ST_IDLE)
    else $error("command taken while busy");

  assert property (@(posedge clk) disable iff (rst) state == ST_FILL |=> state == ST_IDLE)
    else $error("refill longer than one cycle");

  assert property (@(posedge clk) disable iff (rst)
    div_start |-> state == ST_IDLE && tos != '0)
    else $error("divide started with zero divisor");

endmodule

// ----- hdl/integer_stack_machine_top.sv -----
// start, push, pop, negate, dup, swap, add and sub retire in idle; pop, add, sub, mul, div and
// mod on three or more entries then refill in the fill state; mul passes the mul state, div and
// mod the div state (one quotient bit a cycle); end gives its result beat on the cycle after
// it leaves the 2-beat command queue; the execute stage holds one instruction at a time
// reset clears stack depth, error flag and both queues; the stack memory is not cleared
`timescale 1ns / 1ps

module integer_stack_machine_top import ism_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  ism_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  ism_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
